FILE: rtl/awpu_pkg.sv
// Shared widths, item types and fixed-point helpers for the wave point update.
package awpu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int SPEED_W   = 31;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;

	// Second differences and 2*c - p need two extra bits.
	localparam int DIFF_W = DATA_W + 2;
	// Rounded coefficient times difference, plus a sign bit.
	localparam int TERM_W = CFG_W + DIFF_W - FRAC_BITS + 1;
	// Sum of five terms.
	localparam int NUM_W  = TERM_W + 2;

	// Reciprocal divider widths.
	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int DEN_W  = CFG_W + 1;
	localparam int DIVD_W = (2 * FRAC_BITS + 1 > DEN_W) ? 2 * FRAC_BITS + 2 : DEN_W + 1;
	localparam int REM_W  = DEN_W + 1;

	// Final scaling product widths.
	localparam int PROD_W = QUO_W + NUM_W;
	localparam int RMAG_W = PROD_W + 1 - FRAC_BITS;

	localparam int TDATA_W = 288;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP    = 2'd0,
		REG_STEP_OVER_DX = 2'd1,
		REG_STEP_OVER_DZ = 2'd2
	} cfg_reg_t;

	// One grid point as it enters the block.
	typedef struct packed {
		logic signed [DATA_W-1:0] now_center;
		logic signed [DATA_W-1:0] now_left;
		logic signed [DATA_W-1:0] now_right;
		logic signed [DATA_W-1:0] now_above;
		logic signed [DATA_W-1:0] now_below;
		logic signed [DATA_W-1:0] prior_center;
		logic [SPEED_W-1:0]       wave_speed;
		logic [SPEED_W-1:0]       damping;
		logic signed [DATA_W-1:0] source_next;
		logic                     top_row;
	} point_t;

	// Coefficient stages to reciprocal stages.
	typedef struct packed {
		logic [DEN_W-1:0]         den;
		logic signed [TERM_W-1:0] t_damp;
		logic signed [NUM_W-1:0]  sum_a;
		logic signed [NUM_W-1:0]  sum_b;
	} terms_t;

	// Reciprocal stages to scaling stages.
	typedef struct packed {
		logic [QUO_W-1:0]        recip;
		logic signed [NUM_W-1:0] num;
	} scaled_in_t;

	// Unsigned product shifted right with rounding at one half, clipped to 32 bits.
	function automatic logic [CFG_W-1:0] coef_mul(input logic [CFG_W-1:0] a,
			input logic [CFG_W-1:0] b);
		logic [2*CFG_W:0] p;
		logic [2*CFG_W:0] r;
		p = (2*CFG_W+1)'(a) * (2*CFG_W+1)'(b);
		p = p + ((2*CFG_W+1)'(1) << (FRAC_BITS - 1));
		r = p >> FRAC_BITS;
		if (|r[2*CFG_W:CFG_W]) begin
			return '1;
		end
		return r[CFG_W-1:0];
	endfunction

	// Unsigned coefficient times signed value, magnitude rounded, sign restored.
	function automatic logic signed [TERM_W-1:0] term_mul(input logic [CFG_W-1:0] a,
			input logic signed [DIFF_W-1:0] b);
		logic [DIFF_W-1:0]                 mag;
		logic [CFG_W+DIFF_W-1:0]           p;
		logic [CFG_W+DIFF_W-FRAC_BITS-1:0] r;
		mag = b[DIFF_W-1] ? DIFF_W'(-b) : DIFF_W'(b);
		p = (CFG_W+DIFF_W)'(a) * (CFG_W+DIFF_W)'(mag);
		p = p + ((CFG_W+DIFF_W)'(1) << (FRAC_BITS - 1));
		r = p[CFG_W+DIFF_W-1:FRAC_BITS];
		return b[DIFF_W-1] ? -$signed({1'b0, r}) : $signed({1'b0, r});
	endfunction

endpackage

FILE: rtl/awpu_coef.sv
// Coefficient chain and weighted difference terms, four pipeline stages.
module awpu_coef import awpu_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CFG_W-1:0] time_step,
	input  logic [CFG_W-1:0] step_over_dx,
	input  logic [CFG_W-1:0] step_over_dz,
	input  logic             in_valid,
	output logic             in_ready,
	input  point_t           in_point,
	output logic             out_valid,
	input  logic             out_ready,
	output terms_t           out_terms
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// Stage 1 registers.
	logic [CFG_W-1:0]         ct_s1, ax_s1, az_s1;
	logic signed [DIFF_W-1:0] dxx_s1, dzz_s1, base_s1;
	logic signed [DATA_W-1:0] prv_s1, src_s1;
	logic [SPEED_W-1:0]       vel_s1, dmp_s1;
	// Stage 2 registers.
	logic [CFG_W-1:0]         q0_s2, q1_s2, q2_s2, q3_s2;
	logic signed [DIFF_W-1:0] dxx_s2, dzz_s2, base_s2;
	logic signed [DATA_W-1:0] prv_s2, src_s2;
	logic [SPEED_W-1:0]       dmp_s2;
	// Stage 3 registers.
	logic [CFG_W-1:0]         dq_s3;
	logic signed [TERM_W-1:0] t1_s3, t2_s3, t3_s3;
	logic signed [DIFF_W-1:0] base_s3;
	logic signed [DATA_W-1:0] prv_s3;
	// Stage 4 registers.
	terms_t                   terms_s4;

	logic signed [DIFF_W-1:0] cen_x, lft_x, rgt_x, abv_x, blw_x, prv_x;

	// A stage loads when it is empty or its content moves on.
	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s4;
	assign out_terms = terms_s4;

	assign cen_x = DIFF_W'(in_point.now_center);
	assign lft_x = DIFF_W'(in_point.now_left);
	assign rgt_x = DIFF_W'(in_point.now_right);
	assign abv_x = DIFF_W'(in_point.now_above);
	assign blw_x = DIFF_W'(in_point.now_below);
	assign prv_x = DIFF_W'(in_point.prior_center);

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// Stage 1: first coefficient products, the second differences and 2*c - p.
	always_ff @(posedge clk) begin
		if (en1) begin
			ct_s1   <= coef_mul(CFG_W'(in_point.wave_speed), time_step);
			ax_s1   <= coef_mul(CFG_W'(in_point.wave_speed), step_over_dx);
			az_s1   <= coef_mul(CFG_W'(in_point.wave_speed), step_over_dz);
			dxx_s1  <= lft_x - (cen_x <<< 1) + rgt_x;
			dzz_s1  <= in_point.top_row ? ((blw_x - cen_x) <<< 1)
			                            : (abv_x - (cen_x <<< 1) + blw_x);
			base_s1 <= (cen_x <<< 1) - prv_x;
			prv_s1  <= in_point.prior_center;
			src_s1  <= in_point.source_next;
			vel_s1  <= in_point.wave_speed;
			dmp_s1  <= in_point.damping;
		end
	end

	// Stage 2: squared coefficients.
	always_ff @(posedge clk) begin
		if (en2) begin
			q0_s2   <= coef_mul(CFG_W'(vel_s1), ct_s1);
			q1_s2   <= coef_mul(ct_s1, ct_s1);
			q2_s2   <= coef_mul(ax_s1, ax_s1);
			q3_s2   <= coef_mul(az_s1, az_s1);
			dxx_s2  <= dxx_s1;
			dzz_s2  <= dzz_s1;
			base_s2 <= base_s1;
			prv_s2  <= prv_s1;
			src_s2  <= src_s1;
			dmp_s2  <= dmp_s1;
		end
	end

	// Stage 3: damping coefficient and the source and Laplacian terms.
	always_ff @(posedge clk) begin
		if (en3) begin
			dq_s3   <= coef_mul(CFG_W'(dmp_s2), q0_s2);
			t1_s3   <= term_mul(q1_s2, DIFF_W'(src_s2));
			t2_s3   <= term_mul(q2_s2, dxx_s2);
			t3_s3   <= term_mul(q3_s2, dzz_s2);
			base_s3 <= base_s2;
			prv_s3  <= prv_s2;
		end
	end

	// Stage 4: damping term, denominator and two partial sums.
	always_ff @(posedge clk) begin
		if (en4) begin
			terms_s4.t_damp <= term_mul(dq_s3, DIFF_W'(prv_s3));
			terms_s4.den    <= (DEN_W'(1) << FRAC_BITS) + DEN_W'(dq_s3);
			terms_s4.sum_a  <= NUM_W'(t1_s3) + NUM_W'(t2_s3);
			terms_s4.sum_b  <= NUM_W'(t3_s3) + NUM_W'(base_s3);
		end
	end

endmodule

FILE: rtl/awpu_recip.sv
// Pipelined restoring divider for the rounded reciprocal, one quotient bit per stage.
module awpu_recip import awpu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  terms_t     in_terms,
	output logic       out_valid,
	input  logic       out_ready,
	output scaled_in_t out_data
);

	typedef struct packed {
		logic [REM_W-1:0]        rem;
		logic [QUO_W-1:0]        quo;
		logic [DIVD_W-1:0]       divd;
		logic [DEN_W-1:0]        den;
		logic signed [NUM_W-1:0] num;
	} div_stage_t;

	div_stage_t       div_s [QUO_W];
	logic [QUO_W-1:0] valid_s;
	logic [QUO_W-1:0] en;

	assign in_ready       = en[0];
	assign out_valid      = valid_s[QUO_W-1];
	assign out_data.recip = div_s[QUO_W-1].quo;
	assign out_data.num   = div_s[QUO_W-1].num;

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		logic [REM_W-1:0]        rem_in;
		logic [QUO_W-1:0]        quo_in;
		logic [DIVD_W-1:0]       divd_in;
		logic [DEN_W-1:0]        den_in;
		logic signed [NUM_W-1:0] num_in;
		logic                    valid_in;
		logic [REM_W-1:0]        rem_sh;
		logic                    take;

		// Stage input: from the item entering, or from the stage before.
		if (k == 0) begin : g_first
			assign den_in   = in_terms.den;
			assign divd_in  = (DIVD_W'(1) << (2 * FRAC_BITS)) + DIVD_W'(in_terms.den >> 1);
			assign rem_in   = REM_W'(divd_in >> QUO_W);
			assign quo_in   = '0;
			assign num_in   = in_terms.sum_a + in_terms.sum_b + NUM_W'(in_terms.t_damp);
			assign valid_in = in_valid;
		end else begin : g_next
			assign den_in   = div_s[k-1].den;
			assign divd_in  = div_s[k-1].divd;
			assign rem_in   = div_s[k-1].rem;
			assign quo_in   = div_s[k-1].quo;
			assign num_in   = div_s[k-1].num;
			assign valid_in = valid_s[k-1];
		end

		if (k == QUO_W - 1) begin : g_last
			assign en[k] = !valid_s[k] || out_ready;
		end else begin : g_mid
			assign en[k] = !valid_s[k] || en[k+1];
		end

		// Shift in the next dividend bit and subtract where the divisor fits.
		assign rem_sh = {rem_in[REM_W-2:0], divd_in[QUO_W-1-k]};
		assign take   = rem_sh >= REM_W'(den_in);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en[k]) begin
				valid_s[k] <= valid_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				div_s[k].rem  <= take ? rem_sh - REM_W'(den_in) : rem_sh;
				div_s[k].quo  <= quo_in | (QUO_W'(take) << (QUO_W - 1 - k));
				div_s[k].divd <= divd_in;
				div_s[k].den  <= den_in;
				div_s[k].num  <= num_in;
			end
		end
	end

endmodule

FILE: rtl/awpu_scale.sv
// Final scaling by the reciprocal, rounding, saturation and the output register.
module awpu_scale import awpu_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scaled_in_t        in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [DATA_W-1:0] next_value,
	output logic              saturated
);

	localparam logic [RMAG_W-1:0] POS_LIMIT = (RMAG_W'(1) << (DATA_W - 1)) - RMAG_W'(1);
	localparam logic [RMAG_W-1:0] NEG_LIMIT = RMAG_W'(1) << (DATA_W - 1);

	logic              v_s1, v_s2;
	logic              en1, en2;
	logic [PROD_W-1:0] prod_s1;
	logic              neg_s1;
	logic [DATA_W-1:0] value_s2;
	logic              sat_s2;

	logic [NUM_W-1:0]  mag;
	logic [PROD_W:0]   rsum;
	logic [RMAG_W-1:0] rmag;

	assign en2        = !v_s2 || out_ready;
	assign en1        = !v_s1 || en2;
	assign in_ready   = en1;
	assign out_valid  = v_s2;
	assign next_value = value_s2;
	assign saturated  = sat_s2;

	assign mag  = in_data.num[NUM_W-1] ? NUM_W'(-in_data.num) : NUM_W'(in_data.num);
	assign rsum = (PROD_W+1)'(prod_s1) + ((PROD_W+1)'(1) << (FRAC_BITS - 1));
	assign rmag = rsum[PROD_W:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	// Stage 1: magnitude of the numerator times the reciprocal.
	always_ff @(posedge clk) begin
		if (en1) begin
			prod_s1 <= PROD_W'(mag) * PROD_W'(in_data.recip);
			neg_s1  <= in_data.num[NUM_W-1];
		end
	end

	// Stage 2: round, restore the sign and clip to the 32-bit range.
	always_ff @(posedge clk) begin
		if (en2) begin
			if (neg_s1) begin
				sat_s2   <= rmag > NEG_LIMIT;
				value_s2 <= (rmag > NEG_LIMIT) ? NEG_LIMIT[DATA_W-1:0]
				                               : DATA_W'(-rmag);
			end else begin
				sat_s2   <= rmag > POS_LIMIT;
				value_s2 <= (rmag > POS_LIMIT) ? POS_LIMIT[DATA_W-1:0]
				                               : rmag[DATA_W-1:0];
			end
		end
	end

endmodule

FILE: rtl/acoustic_wave_point_update.sv
// Top level of the damped 2D acoustic wave point update pipeline.
//
// Each item on the slave channel carries one grid point: the current value at
// the point and its four neighbours, the previous value, wave speed, damping,
// next-step source and the top-row flag (in s_tuser). Each item produces
// exactly one item on the master channel with the next field value in m_tdata
// and the saturation flag in m_tuser.
// The three time step registers are written through the cfg channel, which is
// always ready; the index selects time_step, step_over_dx or step_over_dz and
// other indexes are ignored. Write them only while no item is in flight.
// The pipeline has four coefficient stages, seventeen divider stages
// (one reciprocal bit each) and two scaling stages. One item enters per cycle unless the pipeline is full and held.
// Every stage has its own valid bit and loads when it is empty or its content
// moves on, so a stalled master channel fills bubbles first and then holds
// the pipeline without losing or repeating items.
// Reset clears all valid bits and sets the three time step registers to zero.
module acoustic_wave_point_update import awpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Slave channel.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// Fields from bit 0: now_center, now_left, now_right, now_above, now_below,
	// prior_center, wave_speed, damping, source_next, zero padding.
	input  logic [TDATA_W-1:0]   s_tdata,
	// top_row.
	input  logic                 s_tuser,
	// Master channel.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// next_value.
	output logic [DATA_W-1:0]    m_tdata,
	// saturated.
	output logic                 m_tuser,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic [CFG_W-1:0] time_step_q, step_over_dx_q, step_over_dz_q;
	point_t           point;
	logic             coef_valid, recip_ready;
	terms_t           terms;
	logic             recip_valid, scale_ready;
	scaled_in_t       scale_in;

	// Unpack the slave item.
	assign point.now_center   = s_tdata[31:0];
	assign point.now_left     = s_tdata[63:32];
	assign point.now_right    = s_tdata[95:64];
	assign point.now_above    = s_tdata[127:96];
	assign point.now_below    = s_tdata[159:128];
	assign point.prior_center = s_tdata[191:160];
	assign point.wave_speed   = s_tdata[222:192];
	assign point.damping      = s_tdata[253:223];
	assign point.source_next  = s_tdata[285:254];
	assign point.top_row      = s_tuser;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q    <= '0;
			step_over_dx_q <= '0;
			step_over_dz_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_TIME_STEP:    time_step_q    <= cfg_data;
				REG_STEP_OVER_DX: step_over_dx_q <= cfg_data;
				REG_STEP_OVER_DZ: step_over_dz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	awpu_coef u_coef (
		.clk          (clk),
		.arst_n       (arst_n),
		.time_step    (time_step_q),
		.step_over_dx (step_over_dx_q),
		.step_over_dz (step_over_dz_q),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_point     (point),
		.out_valid    (coef_valid),
		.out_ready    (recip_ready),
		.out_terms    (terms)
	);

	awpu_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coef_valid),
		.in_ready  (recip_ready),
		.in_terms  (terms),
		.out_valid (recip_valid),
		.out_ready (scale_ready),
		.out_data  (scale_in)
	);

	awpu_scale u_scale (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (recip_valid),
		.in_ready   (scale_ready),
		.in_data    (scale_in),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.next_value (m_tdata),
		.saturated  (m_tuser)
	);

endmodule

FILE: test/acoustic_wave_point_update_check.sv
// Checker for the wave point update: predicts each next field value and compares results.
`timescale 1ns / 1ps
module acoustic_wave_point_update_check import awpu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [DATA_W-1:0]    m_tdata,
	input  logic                 m_tuser,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   errors,
	output int                   pending
);

	typedef struct packed {
		logic [DATA_W-1:0] next_value;
		logic              saturated;
	} update_t;

	logic [CFG_W-1:0] dt_reg;
	logic [CFG_W-1:0] dtdx_reg;
	logic [CFG_W-1:0] dtdz_reg;
	update_t          expected_updates[$];

	// Exact product, shifted right by the fraction bits with the magnitude rounded at one half.
	function automatic logic [63:0] scale_round(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b} + (128'd1 << (FRAC_BITS - 1));
		return p[FRAC_BITS+63:FRAC_BITS];
	endfunction

	// Coefficient product clipped to 32 bits.
	function automatic logic [63:0] coef_of(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		r = scale_round(a, b);
		return (r > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : r;
	endfunction

	// Unsigned coefficient times signed value with the sign restored after rounding.
	function automatic longint signed_term(input logic [63:0] a, input longint b);
		logic [63:0] m;
		logic [63:0] r;
		m = (b < 0) ? 64'(-b) : 64'(b);
		r = scale_round(a, m);
		return (b < 0) ? -longint'(r) : longint'(r);
	endfunction

	function automatic update_t predict_update(input point_t p);
		logic [63:0] vel, ct, q0, q1, ax, q2, az, q3, dq, den, recip;
		longint      cen, dxx, dzz, num, res;
		update_t     u;
		vel = 64'(p.wave_speed);
		ct = coef_of(vel, 64'(dt_reg));
		q0 = coef_of(vel, ct);
		q1 = coef_of(ct, ct);
		ax = coef_of(vel, 64'(dtdx_reg));
		q2 = coef_of(ax, ax);
		az = coef_of(vel, 64'(dtdz_reg));
		q3 = coef_of(az, az);
		dq = coef_of(64'(p.damping), q0);
		den = (64'd1 << FRAC_BITS) + dq;
		recip = ((64'd1 << (2 * FRAC_BITS)) + den / 2) / den;
		cen = longint'(p.now_center);
		dxx = longint'(p.now_left) - 2 * cen + longint'(p.now_right);
		// The top row mirrors the row below in place of the missing row above.
		if (p.top_row) begin
			dzz = 2 * (longint'(p.now_below) - cen);
		end else begin
			dzz = longint'(p.now_above) - 2 * cen + longint'(p.now_below);
		end
		num = 2 * cen - longint'(p.prior_center);
		num += signed_term(dq, longint'(p.prior_center));
		num += signed_term(q1, longint'(p.source_next));
		num += signed_term(q2, dxx);
		num += signed_term(q3, dzz);
		res = signed_term(recip, num);
		u.saturated = 1'b0;
		if (res > 64'sh7FFF_FFFF) begin
			res = 64'sh7FFF_FFFF;
			u.saturated = 1'b1;
		end else if (res < -64'sh8000_0000) begin
			res = -64'sh8000_0000;
			u.saturated = 1'b1;
		end
		u.next_value = res[31:0];
		return u;
	endfunction

	assign pending = expected_updates.size();

	// Register shadow follows accepted configuration writes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_reg   <= '0;
			dtdx_reg <= '0;
			dtdz_reg <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_TIME_STEP:    dt_reg   <= cfg_data;
				REG_STEP_OVER_DX: dtdx_reg <= cfg_data;
				REG_STEP_OVER_DZ: dtdz_reg <= cfg_data;
				default: ;
			endcase
		end
	end

	initial errors = 0;

	// Accepted input items queue their predicted update; results are checked in order.
	always @(posedge clk) begin
		point_t  p;
		update_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				p.now_center   = s_tdata[31:0];
				p.now_left     = s_tdata[63:32];
				p.now_right    = s_tdata[95:64];
				p.now_above    = s_tdata[127:96];
				p.now_below    = s_tdata[159:128];
				p.prior_center = s_tdata[191:160];
				p.wave_speed   = s_tdata[222:192];
				p.damping      = s_tdata[253:223];
				p.source_next  = s_tdata[285:254];
				p.top_row      = s_tuser;
				expected_updates.push_back(predict_update(p));
			end
			if (m_tvalid && m_tready) begin
				if (expected_updates.size() == 0) begin
					$display("%0t: unexpected item next_value=%h saturated=%b",
						$time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_updates.pop_front();
					if (m_tdata !== want.next_value) begin
						$display("%0t: next_value expected %h actual %h",
							$time, want.next_value, m_tdata);
						errors++;
					end
					if (m_tuser !== want.saturated) begin
						$display("%0t: saturated expected %b actual %b",
							$time, want.saturated, m_tuser);
						errors++;
					end
				end
			end
		end
	end

endmodule

FILE: test/acoustic_wave_point_update_test.sv
// Stimulus and verdict for the wave point update, with the checker beside the block.
`timescale 1ns / 1ps
module acoustic_wave_point_update_test;
	import awpu_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [DATA_W-1:0]    m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	int                   errors;
	int                   pending;
	int                   idle_cycles;
	bit                   hold_go;
	bit                   hold_done;

	acoustic_wave_point_update u_dut (.*);

	acoustic_wave_point_update_check u_check (.*);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Watchdog: ends the run when no channel moves for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Mostly short gaps, a few long ones.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Values biased toward the extremes and toward moderate field amplitudes.
	function automatic logic [31:0] field_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			3, 4: return $urandom();
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	function automatic logic [30:0] speed_value();
		case ($urandom_range(0, 9))
			0: return 31'h7FFF_FFFF;
			1: return 31'h0;
			2: return 31'($urandom());
			default: return 31'($urandom_range(32'h0000_4000, 32'h0004_0000));
		endcase
	endfunction

	function automatic logic [30:0] damping_value();
		case ($urandom_range(0, 9))
			0: return 31'h7FFF_FFFF;
			1, 2: return 31'h0;
			3: return 31'($urandom());
			default: return 31'($urandom_range(0, 32'h0010_0000));
		endcase
	endfunction

	function automatic point_t random_point();
		point_t p;
		p.now_center   = field_value();
		p.now_left     = field_value();
		p.now_right    = field_value();
		p.now_above    = field_value();
		p.now_below    = field_value();
		p.prior_center = field_value();
		p.wave_speed   = speed_value();
		p.damping      = damping_value();
		p.source_next  = field_value();
		p.top_row      = $urandom_range(0, 3) == 0;
		return p;
	endfunction

	function automatic point_t flat_point(input logic [31:0] v, input logic [30:0] speed,
			input logic [30:0] damp, input logic top);
		point_t p;
		p = '{v, v, v, v, v, v, speed, damp, v, top};
		return p;
	endfunction

	task automatic send_point(input point_t p);
		int gap;
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, p.source_next, p.damping, p.wave_speed, p.prior_center,
			p.now_below, p.now_above, p.now_right, p.now_left, p.now_center};
		s_tuser  <= p.top_row;
		do @(posedge clk); while (!s_tready);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Writes all three registers, plus one write to the unused index, with the block idle.
	task automatic write_regs(input logic [31:0] dt, input logic [31:0] dtdx,
			input logic [31:0] dtdz);
		logic [CFG_IDX_W-1:0] idx[4];
		logic [31:0]          val[4];
		idx = '{REG_TIME_STEP, REG_STEP_OVER_DX, REG_STEP_OVER_DZ, REG_UNUSED};
		val = '{dt, dtdx, dtdz, $urandom()};
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(input int count);
		for (int i = 0; i < count; i++) send_point(random_point());
	endtask

	// Receiver: random stalls, plus one long hold-off during the last phase while the
	// sender keeps offering items.
	initial begin
		int len;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!hold_done && hold_go) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_done = 1'b1;
			end else if ($urandom_range(0, 9) < 7) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end else begin
				len = pick_gap();
				m_tready <= 1'b0;
				repeat (len > 0 ? len : 1) @(posedge clk);
			end
		end
	end

	initial begin
		point_t p;
		idle_cycles = 0;
		hold_go   = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TIME_STEP;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n = 1'b1;

		// Directed points: field extremes, both row kinds, zero and heavy damping, clipping.
		write_regs(32'h0000_1000, 32'h0000_4000, 32'h0000_6000);
		send_point(flat_point(32'h0, 31'h0, 31'h0, 1'b0));
		send_point(flat_point(32'h7FFF_FFFF, 31'h0001_0000, 31'h0, 1'b0));
		send_point(flat_point(32'h8000_0000, 31'h0001_0000, 31'h0, 1'b1));
		send_point(flat_point(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0));
		send_point(flat_point(32'h8000_0000, 31'h7FFF_FFFF, 31'h0, 1'b1));
		send_point(flat_point(32'hFFFF_FFFF, 31'h0002_0000, 31'h0001_0000, 1'b0));
		p = flat_point(32'h0001_0000, 31'h0003_0000, 31'h0, 1'b1);
		p.now_below = 32'h7FFF_FFFF;
		p.now_above = 32'h8000_0000;
		send_point(p);
		p.top_row = 1'b0;
		send_point(p);
		p = flat_point(32'h0, 31'h0002_0000, 31'h0000_8000, 1'b0);
		p.now_center   = 32'h7FFF_FFFF;
		p.prior_center = 32'h8000_0000;
		send_point(p);
		p.now_center   = 32'h8000_0000;
		p.prior_center = 32'h7FFF_FFFF;
		send_point(p);
		p = flat_point(32'h0, 31'h0004_0000, 31'h0, 1'b0);
		p.source_next = 32'h7FFF_FFFF;
		send_point(p);
		p.source_next = 32'h8000_0000;
		send_point(p);
		p = flat_point(32'h0002_0000, 31'h0001_0000, 31'h7FFF_FFFF, 1'b1);
		p.prior_center = 32'hFFFE_0000;
		send_point(p);
		for (int i = 0; i < 7; i++) send_point(random_point());

		// Random phases across register settings, extremes among them.
		random_phase(140);
		write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		random_phase(50);
		write_regs(32'h0, 32'h0, 32'h0);
		random_phase(40);
		write_regs($urandom(), $urandom(), $urandom());
		random_phase(40);
		write_regs($urandom_range(0, 32'h0001_0000), $urandom_range(0, 32'h0001_0000),
			$urandom_range(0, 32'h0001_0000));
		// The long receiver hold-off falls into this phase, so the pipeline fills up.
		hold_go = 1'b1;
		random_phase(160);
		s_tvalid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/awpu_pkg.sv
rtl/awpu_coef.sv
rtl/awpu_recip.sv
rtl/awpu_scale.sv
rtl/acoustic_wave_point_update.sv
test/acoustic_wave_point_update_check.sv
test/acoustic_wave_point_update_test.sv
